// ----- design/multiset_random_sampler_table_defines.svh -----
// Assertion macros for the sampler table.
`ifndef MULTISET_RANDOM_SAMPLER_TABLE_DEFINES_SVH
`define MULTISET_RANDOM_SAMPLER_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// Plain property, checked on every edge out of reset.
`define MSRS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Antecedent this cycle, consequent the next.
`define MSRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MSRS_ASSERT(lbl, prop, msg)
`define MSRS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- design/msrs_pkg.sv -----
package msrs_pkg;

	typedef logic signed [31:0] word_t;
	typedef logic [1:0] kind_t;

	localparam kind_t KIND_INSERT = 2'd0;
	localparam kind_t KIND_REMOVE = 2'd1;
	localparam kind_t KIND_SAMPLE = 2'd2;

endpackage

// ----- design/msrs_cell.sv -----
// One storage cell of the ring: takes its neighbour's word on each shift.
module msrs_cell import msrs_pkg::*; (
	input  logic  clk,
	input  logic  shift,
	input  word_t d,
	output word_t q
);

	word_t word_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			word_q <= d;
		end
	end

	assign q = word_q;

endmodule

// ----- design/multiset_random_sampler_table.sv -----
// Multiset random sampler table.
// Command port: a beat (kind, value, random_draw) is taken on a rising edge with
// start high and busy low. busy stays high until the result is produced.
// Result port: flag, sample_value and status are valid for exactly one cycle
// while done is high; there is no back-pressure, the receiver must take it.
// The entries live in a ring of CAPACITY cells that rotates one place a cycle
// while a find or write pass runs; every search or access is one full rotation,
// so the ring is back in its original alignment at the end of each pass.
// Steps from accept to the done cycle:
//   insert (not full)       one find pass
//   remove of absent value  one find pass
//   remove of present value find pass, then write pass
//   sample (non-empty)      index multiply step, then find pass
//   insert into full table, sample of empty table, unused kind: answered straight from idle
// One command at a time; throughput is set by the ring rotation.
// Reset clears the entry count and the control state; the cell contents are
// not reset, entries beyond the count are never used.
`include "multiset_random_sampler_table_defines.svh"

module multiset_random_sampler_table import msrs_pkg::*; #(
	parameter int CAPACITY = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  kind_t       kind,
	input  word_t       value,
	input  logic [15:0] random_draw,
	output logic        done,
	output logic        flag,
	output word_t       sample_value,
	output logic        status
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int PRD_W = CNT_W + 16;
	localparam logic [IDX_W-1:0] K_LAST = IDX_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MULT,
		ST_FIND,
		ST_WRITE
	} state_t;

	state_t state_q;

	// latched command
	kind_t       op_q;
	word_t       val_q;
	logic [15:0] draw_q;

	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] k_q;      // logical index of the word now at the head
	logic [IDX_W-1:0] pos_q;    // lowest match
	logic [IDX_W-1:0] idx_q;    // sample index
	logic             found_q;
	word_t            last_q;   // last live entry, for remove
	word_t            cap_q;    // sampled word

	logic  done_q, flag_q, status_q;
	word_t sample_q;

	// ---------------- ring of cells ----------------
	word_t cell_q [CAPACITY];
	word_t head;
	word_t tail_in;
	logic  shift;

	assign head  = cell_q[0];
	assign shift = (state_q == ST_FIND) || (state_q == ST_WRITE);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_ring
		word_t d;
		if (i == CAPACITY - 1) begin : g_tail
			assign d = tail_in;
		end else begin : g_mid
			assign d = cell_q[i+1];
		end
		msrs_cell u_cell (
			.clk   (clk),
			.shift (shift),
			.d     (d),
			.q     (cell_q[i])
		);
	end

	// ---------------- per-step comparisons ----------------
	logic [CNT_W-1:0] k_ext;
	logic             live;
	logic             match;
	logic             at_last;
	logic             found_n;
	logic             ins_hit;
	logic             rem_hit;
	logic [PRD_W-1:0] prod;

	assign k_ext   = CNT_W'(k_q);
	assign live    = k_ext < count_q;
	assign match   = live && (head == val_q);
	assign at_last = (count_q != '0) && (k_ext == count_q - CNT_W'(1));
	assign found_n = found_q || match;

	// insert appends at the slot just past the live entries
	assign ins_hit = (state_q == ST_FIND) && (op_q == KIND_INSERT) && (k_ext == count_q);
	// remove overwrites the lowest match with the last live entry
	assign rem_hit = (state_q == ST_WRITE) && (k_q == pos_q);

	always_comb begin
		tail_in = head;
		if (ins_hit) begin
			tail_in = val_q;
		end else if (rem_hit) begin
			tail_in = last_q;
		end
	end

	assign prod = PRD_W'(draw_q) * PRD_W'(count_q);

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			k_q      <= '0;
			found_q  <= 1'b0;
			done_q   <= 1'b0;
			flag_q   <= 1'b0;
			status_q <= 1'b0;
			sample_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q     <= kind;
						val_q    <= value;
						draw_q   <= random_draw;
						k_q      <= '0;
						found_q  <= 1'b0;
						cap_q    <= '0;
						flag_q   <= 1'b0;
						status_q <= 1'b0;
						sample_q <= '0;
						case (kind)
							KIND_INSERT: begin
								if (count_q == CNT_FULL) begin
									done_q   <= 1'b1;
									status_q <= 1'b1;
								end else begin
									state_q <= ST_FIND;
								end
							end
							KIND_REMOVE: begin
								state_q <= ST_FIND;
							end
							KIND_SAMPLE: begin
								if (count_q == '0) begin
									done_q <= 1'b1;
								end else begin
									state_q <= ST_MULT;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_MULT: begin
					// index is below count since draw < 2^16
					idx_q   <= prod[16 +: IDX_W];
					state_q <= ST_FIND;
				end
				ST_FIND: begin
					if (match && !found_q) begin
						pos_q <= k_q;
					end
					found_q <= found_n;
					if (at_last) begin
						last_q <= head;
					end
					if ((op_q == KIND_SAMPLE) && (k_q == idx_q)) begin
						cap_q <= head;
					end
					if (k_q == K_LAST) begin
						k_q <= '0;
						case (op_q)
							KIND_INSERT: begin
								count_q <= count_q + CNT_W'(1);
								flag_q  <= !found_n;
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end
							KIND_REMOVE: begin
								if (found_n) begin
									state_q <= ST_WRITE;
								end else begin
									done_q  <= 1'b1;
									state_q <= ST_IDLE;
								end
							end
							default: begin
								sample_q <= (k_q == idx_q) ? head : cap_q;
								done_q   <= 1'b1;
								state_q  <= ST_IDLE;
							end
						endcase
					end else begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				ST_WRITE: begin
					if (k_q == K_LAST) begin
						k_q     <= '0;
						count_q <= count_q - CNT_W'(1);
						flag_q  <= 1'b1;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign flag         = flag_q;
	assign sample_value = sample_q;
	assign status       = status_q;

	// ---------------- checks ----------------
	`MSRS_ASSERT(a_count_range, count_q <= CNT_FULL, "entry count above capacity")
	`MSRS_ASSERT(a_done_idle, done_q |-> (state_q == ST_IDLE), "result beat while still busy")
	`MSRS_ASSERT_NEXT(a_accept_moves, start && !busy, busy || done_q, "accepted beat dropped")
	`MSRS_ASSERT(a_count_on_done, (count_q != $past(count_q)) |-> done_q, "count moved mid-command")
	`MSRS_ASSERT(a_full_clean, (done_q && status_q) |-> (!flag_q && (sample_q == '0)), "rejected insert with payload")

endmodule

// ----- tb/sv/tb_multiset_random_sampler_table.sv -----
`timescale 1ns / 100ps

// Self-checking bench for the multiset random sampler table.
// Commands are queued up front by the stimulus block, pushed onto the command
// port by a falling-edge driver, and predicted at the rising edge on which the
// beat is taken. The done strobe is checked at the rising edge against the
// oldest prediction.
module tb_multiset_random_sampler_table;
	import msrs_pkg::*;

	localparam int CAPACITY = 256;
	// kind code that the package leaves unnamed; the block must answer all zeros
	localparam kind_t KIND_UNUSED = 2'd3;
	// slowest command: find pass plus write pass
	localparam int WORST_LATENCY = 2 * CAPACITY + 1;

	typedef struct {
		kind_t       kind;
		word_t       value;
		logic [15:0] draw;
		bit          drain_first; // hold this beat until nothing is outstanding
	} command_t;

	typedef struct {
		logic  flg;
		word_t smp;
		logic  stat;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	kind_t       kind = KIND_INSERT;
	word_t       value = '0;
	logic [15:0] random_draw = '0;
	logic        done;
	logic        flag;
	word_t       sample_value;
	logic        status;

	multiset_random_sampler_table #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.value(value),
		.random_draw(random_draw),
		.done(done),
		.flag(flag),
		.sample_value(sample_value),
		.status(status)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Shadow of the table, advanced once per accepted beat.
	// ------------------------------------------------------------------
	word_t shadow_words [CAPACITY];
	int    shadow_count = 0;

	command_t pending_cmds [$];
	outcome_t expected_outcomes [$];
	int       err_cnt = 0;
	int       beats_taken = 0;
	int       beats_seen = 0;     // driver's copy of beats_taken
	int       gap_left = 0;
	int       no_idle_left = 0;

	// Lowest live index holding v, or -1.
	function automatic int lowest_match(word_t v);
		for (int i = 0; i < shadow_count; i++) begin
			if (shadow_words[i] == v)
				return i;
		end
		return -1;
	endfunction

	function automatic outcome_t apply_to_table(kind_t k, word_t v, logic [15:0] d);
		outcome_t r;
		int pos;
		int idx;
		r.flg = 1'b0;
		r.smp = '0;
		r.stat = 1'b0;
		case (k)
		KIND_INSERT: begin
			if (shadow_count >= CAPACITY) begin
				// full: nothing stored, rejected
				r.stat = 1'b1;
			end else begin
				r.flg = (lowest_match(v) < 0);
				shadow_words[shadow_count] = v;
				shadow_count++;
			end
		end
		KIND_REMOVE: begin
			pos = lowest_match(v);
			if (pos >= 0) begin
				// last live entry fills the hole; harmless when pos is the last one
				shadow_words[pos] = shadow_words[shadow_count - 1];
				shadow_count--;
				r.flg = 1'b1;
			end
		end
		KIND_SAMPLE: begin
			if (shadow_count != 0) begin
				// draw is a 16-bit fraction, so the index always lands below the count
				idx = (int'(d) * shadow_count) >> 16;
				r.smp = shadow_words[idx];
			end
		end
		default: begin
		end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t: beat %0d %s: got %0h, expected %0h",
			$realtime, beats_taken, what, got, want);
		err_cnt++;
	endtask

	// ------------------------------------------------------------------
	// Rising edge: check the result strobe first, then predict any beat
	// taken on this edge. A result can never come on its own accept edge.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_outcomes.size() == 0) begin
					report_mismatch("result with nothing outstanding", sample_value, 0);
				end else begin
					want = expected_outcomes.pop_front();
					if (flag !== want.flg)
						report_mismatch("flag", flag, want.flg);
					if (sample_value !== want.smp)
						report_mismatch("sample_value", sample_value, want.smp);
					if (status !== want.stat)
						report_mismatch("status", status, want.stat);
				end
			end
			if (start && !busy) begin
				expected_outcomes.push_back(apply_to_table(kind, value, random_draw));
				beats_taken++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Falling edge driver. start stays high across back-to-back beats; the
	// next value is worked out first and assigned once.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		logic     nxt_start;
		command_t c;
		int       r;
		nxt_start = start;
		if (arst_n) begin
			if (start && (beats_taken != beats_seen)) begin
				nxt_start = 1'b0;
				beats_seen = beats_taken;
				// gap before the next beat: mostly none or short, a few long,
				// and now and then a run with no gaps at all
				r = $urandom_range(0, 99);
				if (no_idle_left > 0) begin
					no_idle_left--;
					gap_left = 0;
				end else if (r < 3) begin
					no_idle_left = $urandom_range(20, 60);
					gap_left = 0;
				end else if (r < 60) begin
					gap_left = 0;
				end else if (r < 92) begin
					gap_left = $urandom_range(1, 3);
				end else begin
					gap_left = $urandom_range(10, 60);
				end
			end
			if (!nxt_start) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_cmds.size() > 0 && !(pending_cmds[0].drain_first &&
						(expected_outcomes.size() != 0 || busy))) begin
					c = pending_cmds.pop_front();
					kind <= c.kind;
					value <= c.value;
					random_draw <= c.draw;
					nxt_start = 1'b1;
				end
			end
		end
		start <= nxt_start;
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	// small pool so that duplicates and successful removes are common
	word_t value_pool [12] = '{32'h7FFFFFFF, 32'h80000000, 32'h00000000, 32'hFFFFFFFF,
		32'h00000001, 32'h0000002A, 32'hFFFFFFD6, 32'h55555555, 32'hAAAAAAAA,
		32'h000003E8, 32'h00000007, 32'hFFFFFFF9};

	task automatic add_cmd(kind_t k, word_t v, logic [15:0] d, bit drain = 1'b0);
		command_t c;
		c.kind = k;
		c.value = v;
		c.draw = d;
		c.drain_first = drain;
		pending_cmds.push_back(c);
	endtask

	function automatic word_t pick_value(int pool_pct);
		if ($urandom_range(0, 99) < pool_pct)
			return value_pool[$urandom_range(0, 11)];
		return word_t'($urandom);
	endfunction

	function automatic logic [15:0] pick_draw();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 16'h0000;
		if (r == 1)
			return 16'hFFFF;
		return 16'($urandom);
	endfunction

	// weights in percent for insert, remove and sample; the rest is the unused code
	task automatic add_mixed(int n, int w_ins, int w_rem, int w_smp);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < w_ins)
				add_cmd(KIND_INSERT, pick_value(50), pick_draw(), i == 0);
			else if (r < w_ins + w_rem)
				add_cmd(KIND_REMOVE, pick_value(75), pick_draw(), ($urandom_range(0, 49) == 0));
			else if (r < w_ins + w_rem + w_smp)
				add_cmd(KIND_SAMPLE, pick_value(50), pick_draw());
			else
				add_cmd(KIND_UNUSED, pick_value(50), pick_draw());
		end
	endtask

	initial begin
		// directed: empty-table cases, extremes, duplicates, removal paths
		add_cmd(KIND_SAMPLE, 32'h12345678, 16'hFFFF);        // sample of empty table
		add_cmd(KIND_REMOVE, 32'h00000005, 16'h0000);        // remove from empty table
		add_cmd(KIND_UNUSED, 32'hFFFFFFFF, 16'hFFFF);        // unused code
		add_cmd(KIND_INSERT, 32'h7FFFFFFF, 16'h0000);
		add_cmd(KIND_INSERT, 32'h80000000, 16'hFFFF);
		add_cmd(KIND_INSERT, 32'h7FFFFFFF, 16'h0000);        // duplicate, flag low
		add_cmd(KIND_INSERT, 32'h00000000, 16'h0000);
		add_cmd(KIND_INSERT, 32'hFFFFFFFF, 16'h0000);
		add_cmd(KIND_SAMPLE, 32'h00000000, 16'h0000);        // first slot
		add_cmd(KIND_SAMPLE, 32'hFFFFFFFF, 16'hFFFF);        // last slot
		add_cmd(KIND_SAMPLE, 32'h00000000, 16'h8000);
		add_cmd(KIND_REMOVE, 32'h7FFFFFFF, 16'hFFFF);        // lowest copy, last moves in
		add_cmd(KIND_SAMPLE, 32'h00000000, 16'h0000);
		add_cmd(KIND_REMOVE, 32'h00003039, 16'h0000);        // absent value
		add_cmd(KIND_INSERT, 32'h0000002A, 16'h0000);
		add_cmd(KIND_REMOVE, 32'h0000002A, 16'h0000, 1'b1);  // last entry itself
		add_cmd(KIND_UNUSED, 32'h55555555, 16'hAAAA);
		add_cmd(KIND_REMOVE, 32'h80000000, 16'h0000);
		add_cmd(KIND_REMOVE, 32'h7FFFFFFF, 16'h0000);
		add_cmd(KIND_REMOVE, 32'h00000000, 16'h0000);
		add_cmd(KIND_REMOVE, 32'hFFFFFFFF, 16'h0000);
		add_cmd(KIND_SAMPLE, 32'hAAAAAAAA, 16'h5555);        // empty again

		// random: a short mix, then a fill run that overflows the table with
		// samples sprinkled in, then a removal-heavy mix draining it back
		add_mixed(40, 50, 25, 20);
		for (int i = 0; i < 300; i++) begin
			if (i % 10 == 9)
				add_cmd(KIND_SAMPLE, pick_value(50), pick_draw());
			else
				add_cmd(KIND_INSERT, pick_value(50), pick_draw(), i == 0);
		end
		add_mixed(310, 30, 45, 20);

		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		while (pending_cmds.size() != 0 || start || expected_outcomes.size() != 0)
			@(posedge clk);
		// let any stray strobe show up before the verdict
		repeat (WORST_LATENCY + 4) @(posedge clk);

		if (err_cnt == 0)
			$display("[multiset_random_sampler_table] OK");
		else
			$display("[multiset_random_sampler_table] ERROR");
		$finish;
	end

	// slowest correct run is under a millisecond; allow several times that
	initial begin
		#4000000;
		$display("[multiset_random_sampler_table] ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+design
design/msrs_pkg.sv
design/msrs_cell.sv
design/multiset_random_sampler_table.sv
tb/sv/tb_multiset_random_sampler_table.sv
